// ----- src/bpfl_pkg.sv -----
package bpfl_pkg;

	// Request opcodes
	localparam logic OP_GET  = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// Fixed field widths of the channels
	localparam int ID_W    = 5;
	localparam int COUNT_W = 6;
	localparam int CTR_W   = 32;

	// Class of a request, settled on entry to the queue
	typedef enum logic [1:0] {
		KIND_GET,
		KIND_FREE,
		KIND_REJECT
	} kind_t;

	// Queued command
	typedef struct packed {
		kind_t            kind;
		logic [ID_W-1:0]  id;
	} cmd_t;

	// Result item
	typedef struct packed {
		logic               status;
		logic [ID_W-1:0]    granted_id;
		logic [COUNT_W-1:0] free_count;
		logic [CTR_W-1:0]   gets_done;
		logic [CTR_W-1:0]   gets_failed;
		logic [CTR_W-1:0]   frees_done;
		logic [CTR_W-1:0]   frees_failed;
	} result_t;

endpackage

// ----- src/bpfl_req_if.sv -----
interface bpfl_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [bpfl_pkg::ID_W-1:0]  buffer_id;
	logic                       id_present;

	modport source (output valid, output opcode, output buffer_id, output id_present,
		input ready);
	modport sink (input valid, input opcode, input buffer_id, input id_present,
		output ready);
endinterface

// ----- src/bpfl_rsp_if.sv -----
interface bpfl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [bpfl_pkg::ID_W-1:0]     granted_id;
	logic [bpfl_pkg::COUNT_W-1:0]  free_count;
	logic [bpfl_pkg::CTR_W-1:0]    gets_done;
	logic [bpfl_pkg::CTR_W-1:0]    gets_failed;
	logic [bpfl_pkg::CTR_W-1:0]    frees_done;
	logic [bpfl_pkg::CTR_W-1:0]    frees_failed;

	modport source (output valid, output status, output granted_id, output free_count,
		output gets_done, output gets_failed, output frees_done, output frees_failed,
		input ready);
	modport sink (input valid, input status, input granted_id, input free_count,
		input gets_done, input gets_failed, input frees_done, input frees_failed,
		output ready);
endinterface

// ----- src/bpfl_front.sv -----
module bpfl_front #(
	parameter int POOL_SIZE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bpfl_req_if.sink          req,
	output logic              cmd_valid,
	output bpfl_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	logic           push;
	bpfl_pkg::cmd_t new_cmd;
	bpfl_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	// Classify the incoming item
	always_comb begin
		new_cmd.id = req.buffer_id;
		if (req.opcode == bpfl_pkg::OP_GET) begin
			new_cmd.kind = bpfl_pkg::KIND_GET;
		end else if (req.id_present && (32'(req.buffer_id) < 32'(POOL_SIZE))) begin
			new_cmd.kind = bpfl_pkg::KIND_FREE;
		end else begin
			new_cmd.kind = bpfl_pkg::KIND_REJECT;
		end
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/bpfl_back.sv -----
module bpfl_back #(
	parameter int POOL_SIZE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  bpfl_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	bpfl_rsp_if.source        rsp
);

	localparam int IW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int DW  = $clog2(POOL_SIZE + 1);
	localparam int BW  = (POOL_SIZE < 32) ? POOL_SIZE : 32;
	localparam int BIW = (BW > 1) ? $clog2(BW) : 1;
	localparam int CW  = bpfl_pkg::CTR_W;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [DW-1:0]     depth_q;
	logic [DW-1:0]     lw_q;
	logic [BW-1:0]     busy_q;
	logic [CW-1:0]     gok_q;
	logic [CW-1:0]     gfail_q;
	logic [CW-1:0]     fok_q;
	logic [CW-1:0]     ffail_q;
	logic [IW-1:0]     stack_mem [POOL_SIZE];
	logic [IW-1:0]     rd_data_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              fresh_s1;
	bpfl_pkg::result_t res_q;
	logic              res_valid_q;

	logic              slot_free;
	logic              take;
	logic [DW-1:0]     depth_m1;
	logic [IW-1:0]     top_idx;
	logic [IW-1:0]     push_idx;
	logic              can_pop;
	logic              can_push;
	logic [BIW-1:0]    free_bidx;
	logic              free_ok;
	logic              get_ok;
	logic              gok_inc;
	logic              gfail_inc;
	logic              fok_inc;
	logic              ffail_inc;
	logic [DW-1:0]     depth_n;
	logic [CW-1:0]     gok_n;
	logic [CW-1:0]     gfail_n;
	logic [CW-1:0]     fok_n;
	logic [CW-1:0]     ffail_n;
	logic [IW-1:0]     granted;
	logic              granted_tracked;
	logic              res_load;

	// Decide what the head command does
	always_comb begin
		slot_free = !res_valid_q || rsp.ready;
		take      = (state_q == ST_IDLE) && cmd_valid && slot_free;
		depth_m1  = depth_q - DW'(1);
		top_idx   = IW'(depth_m1);
		push_idx  = IW'(depth_q);
		can_pop   = (depth_q != '0);
		can_push  = (depth_q < DW'(POOL_SIZE));
		free_bidx = cmd.id[BIW-1:0];
		get_ok    = (cmd.kind == bpfl_pkg::KIND_GET) && can_pop;
		free_ok   = (cmd.kind == bpfl_pkg::KIND_FREE) && busy_q[free_bidx] && can_push;
		gok_inc   = take && get_ok;
		gfail_inc = take && (cmd.kind == bpfl_pkg::KIND_GET) && !can_pop;
		fok_inc   = take && free_ok;
		ffail_inc = take && (cmd.kind != bpfl_pkg::KIND_GET) && !free_ok;
		gok_n     = gok_q + CW'(gok_inc);
		gfail_n   = gfail_q + CW'(gfail_inc);
		fok_n     = fok_q + CW'(fok_inc);
		ffail_n   = ffail_q + CW'(ffail_inc);
		if (gok_inc) begin
			depth_n = depth_m1;
		end else if (fok_inc) begin
			depth_n = depth_q + DW'(1);
		end else begin
			depth_n = depth_q;
		end
		// entries below the low-water mark still hold their reset id
		granted         = fresh_s1 ? rd_idx_s1 : rd_data_s1;
		granted_tracked = (32'(granted) < 32'(BW));
		// a result is loaded by the read stage or by a command that is not a successful get
		res_load        = (state_q == ST_READ) || (take && !get_ok);
	end

	assign cmd_pop          = take;
	assign rsp.valid        = res_valid_q;
	assign rsp.status       = res_q.status;
	assign rsp.granted_id   = res_q.granted_id;
	assign rsp.free_count   = res_q.free_count;
	assign rsp.gets_done    = res_q.gets_done;
	assign rsp.gets_failed  = res_q.gets_failed;
	assign rsp.frees_done   = res_q.frees_done;
	assign rsp.frees_failed = res_q.frees_failed;

	// Push freed ids and read the stack top
	always_ff @(posedge clk) begin
		if (fok_inc) begin
			stack_mem[push_idx] <= IW'(cmd.id);
		end
		if (gok_inc) begin
			rd_data_s1 <= stack_mem[top_idx];
		end
	end

	// Hold state, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= DW'(POOL_SIZE);
			lw_q        <= DW'(POOL_SIZE);
			busy_q      <= '0;
			gok_q       <= '0;
			gfail_q     <= '0;
			fok_q       <= '0;
			ffail_q     <= '0;
			rd_idx_s1   <= '0;
			fresh_s1    <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			depth_q <= depth_n;
			gok_q   <= gok_n;
			gfail_q <= gfail_n;
			fok_q   <= fok_n;
			ffail_q <= ffail_n;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (get_ok) begin
							rd_idx_s1 <= top_idx;
							fresh_s1  <= (depth_m1 < lw_q);
							if (depth_m1 < lw_q) begin
								lw_q <= depth_m1;
							end
							state_q <= ST_READ;
						end else begin
							if (free_ok) begin
								busy_q[free_bidx] <= 1'b0;
							end
							res_q.status       <= !free_ok;
							res_q.granted_id   <= '0;
							res_q.free_count   <= bpfl_pkg::COUNT_W'(depth_n);
							res_q.gets_done    <= gok_n;
							res_q.gets_failed  <= gfail_n;
							res_q.frees_done   <= fok_n;
							res_q.frees_failed <= ffail_n;
						end
					end
				end
				ST_READ: begin
					// mark the popped id busy and report it
					if (granted_tracked) begin
						busy_q[granted[BIW-1:0]] <= 1'b1;
					end
					res_q.status       <= 1'b0;
					res_q.granted_id   <= bpfl_pkg::ID_W'(granted);
					res_q.free_count   <= bpfl_pkg::COUNT_W'(depth_q);
					res_q.gets_done    <= gok_q;
					res_q.gets_failed  <= gfail_q;
					res_q.frees_done   <= fok_q;
					res_q.frees_failed <= ffail_q;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/buffer_pool_free_list.sv -----
// Channel  Role    Items
// req      sink    opcode, buffer_id, id_present
// rsp      source  status, granted_id, free_count, gets_done, gets_failed,
//                  frees_done, frees_failed
//
// In the back end a successful get first does the registered read of the
// free-id stack memory, then marks the id busy and loads the result. A free
// or a failed request loads its result when taken. A 2-entry queue sits ahead.
// Reset needs no clearing pass: a low-water mark stands in for the initial ids.
// A stalled rsp holds its result while req still fills the queue.
module buffer_pool_free_list #(
	parameter int POOL_SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	bpfl_req_if.sink    req,
	bpfl_rsp_if.source  rsp
);

	logic           cmd_valid;
	bpfl_pkg::cmd_t cmd;
	logic           cmd_pop;

	// Accept and classify requests
	bpfl_front #(
		.POOL_SIZE (POOL_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Execute against the stack and busy map
	bpfl_back #(
		.POOL_SIZE (POOL_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule

// ----- tb/sv/tb_buffer_pool_free_list.sv -----
`timescale 1ns / 100ps

module tb_buffer_pool_free_list;

	localparam int POOL       = 32;
	localparam int DIR_ROWS   = 16;
	localparam int RAND_ITEMS = 1550;
	localparam int TAIL_WAIT  = 16;
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_FAIL  = 1'b1;

	// One row of the directed part; want is used only where typed is set
	typedef struct packed {
		logic                          op;
		logic [bpfl_pkg::ID_W-1:0]     id;
		logic                          present;
		logic [5:0]                    reps;
		logic                          typed;
		bpfl_pkg::result_t             want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpfl_req_if req_if ();
	bpfl_rsp_if rsp_if ();

	buffer_pool_free_list #(
		.POOL_SIZE(POOL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Free-list mirror
	logic [bpfl_pkg::ID_W-1:0]  free_ids [POOL];
	int                         free_depth;
	logic [POOL-1:0]            held_ids;
	logic [bpfl_pkg::CTR_W-1:0] n_get_ok, n_get_fail, n_free_ok, n_free_fail;

	bpfl_pkg::result_t due_results [$];
	stim_row_t         dir_rows [DIR_ROWS];
	int                mismatches = 0;
	int                results_seen = 0;
	int                items_sent = 0;
	bit                req_quiet = 1'b0;
	bit                rsp_quiet = 1'b0;
	int                rsp_hold = 0;
	int                rsp_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the mirror by one request and return the result it yields
	function automatic bpfl_pkg::result_t next_pool_result(input logic op,
		input logic [bpfl_pkg::ID_W-1:0] id, input logic present);
		bpfl_pkg::result_t r;
		r = '0;
		r.status = ST_FAIL;
		if (op == bpfl_pkg::OP_GET) begin
			if (free_depth > 0) begin
				free_depth--;
				r.granted_id = free_ids[free_depth];
				held_ids[r.granted_id] = 1'b1;
				r.status = ST_OK;
				n_get_ok++;
			end else begin
				n_get_fail++;
			end
		end else if (present && held_ids[id] && free_depth < POOL) begin
			held_ids[id] = 1'b0;
			free_ids[free_depth] = id;
			free_depth++;
			r.status = ST_OK;
			n_free_ok++;
		end else begin
			n_free_fail++;
		end
		r.free_count = free_depth[bpfl_pkg::COUNT_W-1:0];
		r.gets_done = n_get_ok;
		r.gets_failed = n_get_fail;
		r.frees_done = n_free_ok;
		r.frees_failed = n_free_fail;
		return r;
	endfunction

	// Random id among those handed out, or -1 when none is
	function automatic int pick_held_id();
		int ids [$];
		for (int i = 0; i < POOL; i++)
			if (held_ids[i])
				ids.insert(ids.size(), i);
		if (ids.size() == 0)
			return -1;
		return ids[$urandom_range(0, ids.size() - 1)];
	endfunction

	// Present one request, hold it until taken, then queue its result
	task automatic issue_request(input logic op, input logic [bpfl_pkg::ID_W-1:0] id,
		input logic present, input logic typed, input bpfl_pkg::result_t typed_want);
		int gap;
		bpfl_pkg::result_t model_res;
		gap = pick_gap(req_quiet);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= op;
		req_if.buffer_id <= id;
		req_if.id_present <= present;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		model_res = next_pool_result(op, id, present);
		due_results.insert(due_results.size(), typed ? typed_want : model_res);
		items_sent++;
	endtask

	task automatic flag_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at result %0d, %s: expected %0h, got %0h",
				results_seen, what, want, got);
	endtask

	// Result side: stall at random, with calm stretches
	always @(posedge clk) begin
		rsp_cycles <= rsp_cycles + 1;
		if (rsp_cycles % 300 == 0)
			rsp_quiet <= ($urandom_range(0, 3) == 0);
		if (rsp_hold > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_if.ready <= 1'b1;
			rsp_hold <= pick_gap(rsp_quiet);
		end
	end

	// Compare each result with the oldest one due
	always @(posedge clk) begin
		bpfl_pkg::result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (due_results.size() == 0) begin
				flag_field("result with nothing due, free_count", '0,
					32'(rsp_if.free_count));
			end else begin
				want = due_results.pop_front();
				if (rsp_if.status !== want.status)
					flag_field("status", 32'(want.status), 32'(rsp_if.status));
				if (rsp_if.granted_id !== want.granted_id)
					flag_field("granted_id", 32'(want.granted_id),
						32'(rsp_if.granted_id));
				if (rsp_if.free_count !== want.free_count)
					flag_field("free_count", 32'(want.free_count),
						32'(rsp_if.free_count));
				if (rsp_if.gets_done !== want.gets_done)
					flag_field("gets_done", want.gets_done, rsp_if.gets_done);
				if (rsp_if.gets_failed !== want.gets_failed)
					flag_field("gets_failed", want.gets_failed, rsp_if.gets_failed);
				if (rsp_if.frees_done !== want.frees_done)
					flag_field("frees_done", want.frees_done, rsp_if.frees_done);
				if (rsp_if.frees_failed !== want.frees_failed)
					flag_field("frees_failed", want.frees_failed, rsp_if.frees_failed);
			end
			results_seen++;
		end
	end

	initial begin
		#20_000_000;
		$display("timeout: %0d results still due", due_results.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		int get_pct;
		int pick;
		int r;
		logic op;
		logic [bpfl_pkg::ID_W-1:0] id;
		logic present;

		req_if.valid <= 1'b0;
		req_if.opcode <= bpfl_pkg::OP_GET;
		req_if.buffer_id <= '0;
		req_if.id_present <= 1'b0;

		// Mirror starts as after reset: ids 0 up to 31, top is 31
		for (int i = 0; i < POOL; i++)
			free_ids[i] = i[bpfl_pkg::ID_W-1:0];
		held_ids = '0;
		free_depth = POOL;
		n_get_ok = '0;
		n_get_fail = '0;
		n_free_ok = '0;
		n_free_fail = '0;

		dir_rows = '{
			'{bpfl_pkg::OP_GET,  5'd0,  1'b1, 6'd1,  1'b1,
				'{ST_OK,   5'd31, 6'd31, 32'd1,  32'd0, 32'd0, 32'd0}},
			'{bpfl_pkg::OP_FREE, 5'd5,  1'b0, 6'd1,  1'b1,
				'{ST_FAIL, 5'd0,  6'd31, 32'd1,  32'd0, 32'd0, 32'd1}},
			'{bpfl_pkg::OP_FREE, 5'd0,  1'b1, 6'd1,  1'b1,
				'{ST_FAIL, 5'd0,  6'd31, 32'd1,  32'd0, 32'd0, 32'd2}},
			'{bpfl_pkg::OP_FREE, 5'd31, 1'b1, 6'd1,  1'b1,
				'{ST_OK,   5'd0,  6'd32, 32'd1,  32'd0, 32'd1, 32'd2}},
			'{bpfl_pkg::OP_FREE, 5'd31, 1'b1, 6'd1,  1'b1,
				'{ST_FAIL, 5'd0,  6'd32, 32'd1,  32'd0, 32'd1, 32'd3}},
			'{bpfl_pkg::OP_GET,  5'd31, 1'b0, 6'd1,  1'b1,
				'{ST_OK,   5'd31, 6'd31, 32'd2,  32'd0, 32'd1, 32'd3}},
			'{bpfl_pkg::OP_GET,  5'd10, 1'b1, 6'd31, 1'b0, '0},
			'{bpfl_pkg::OP_GET,  5'd0,  1'b0, 6'd1,  1'b1,
				'{ST_FAIL, 5'd0,  6'd0,  32'd33, 32'd1, 32'd1, 32'd3}},
			'{bpfl_pkg::OP_GET,  5'd21, 1'b1, 6'd1,  1'b1,
				'{ST_FAIL, 5'd0,  6'd0,  32'd33, 32'd2, 32'd1, 32'd3}},
			'{bpfl_pkg::OP_FREE, 5'd0,  1'b1, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_FREE, 5'd31, 1'b0, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_FREE, 5'd10, 1'b1, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_GET,  5'd0,  1'b0, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_FREE, 5'd16, 1'b1, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_FREE, 5'd21, 1'b1, 6'd1,  1'b0, '0},
			'{bpfl_pkg::OP_GET,  5'd0,  1'b0, 6'd1,  1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first grant, null and idle frees, double free, empty pool
		for (int i = 0; i < DIR_ROWS; i++)
			for (int k = 0; k < dir_rows[i].reps; k++)
				issue_request(dir_rows[i].op, dir_rows[i].id, dir_rows[i].present,
					dir_rows[i].typed, dir_rows[i].want);

		// Random part: phases that lean to draining or refilling the pool
		get_pct = 50;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 125 == 0) begin
				case ($urandom_range(0, 2))
					0: get_pct = 15;
					1: get_pct = 50;
					default: get_pct = 85;
				endcase
				req_quiet = ($urandom_range(0, 3) == 0);
			end

			// Hold off once until every result is back
			if (n == RAND_ITEMS / 2) begin
				req_if.valid <= 1'b0;
				do
					@(posedge clk);
				while (due_results.size() != 0);
			end

			id = bpfl_pkg::ID_W'($urandom_range(0, POOL - 1));
			present = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < get_pct) begin
				op = bpfl_pkg::OP_GET;
			end else begin
				op = bpfl_pkg::OP_FREE;
				r = $urandom_range(0, 99);
				pick = pick_held_id();
				if (r < 80 && pick >= 0) begin
					id = pick[bpfl_pkg::ID_W-1:0];
					present = 1'b1;
				end else if (r < 90) begin
					present = 1'b0;
				end
			end
			issue_request(op, id, present, 1'b0, '0);
		end

		// Drain
		req_if.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("%0d requests: %0d grants, %0d gets refused, %0d frees, %0d frees refused",
			items_sent, n_get_ok, n_get_fail, n_free_ok, n_free_fail);
		$display("%0d results checked, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
